### hw/rtl/adp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adp_pkg
// Shared types and codes of the advertising-data phone classifier.
// ----------------------------------------------------------------------------
package adp_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_APPEAR_TYPE = 3'd0;
    localparam logic [2:0] REG_MANU_TYPE   = 3'd1;
    localparam logic [2:0] REG_PHONE_CODE  = 3'd2;
    localparam logic [2:0] REG_ID_COUNT    = 3'd3;
    localparam logic [2:0] REG_ID_WORD_A   = 3'd4;
    localparam logic [2:0] REG_ID_WORD_B   = 3'd5;
    localparam logic [2:0] REG_ID_WORD_C   = 3'd6;

    // register reset values
    localparam logic [7:0]  RST_APPEAR_TYPE = 8'd25;
    localparam logic [7:0]  RST_MANU_TYPE   = 8'd255;
    localparam logic [15:0] RST_PHONE_CODE  = 16'h0040;

    localparam int TABLE_ENTRIES = 12;

    // walk phase of the length-type-payload parser
    typedef enum logic [1:0] {
        PH_LENGTH  = 2'd0,
        PH_TYPE    = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    // verdict kind
    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_APPEAR  = 2'd1,
        KIND_COMPANY = 2'd2
    } t_kind;

    // configuration seen by the walker
    typedef struct packed {
        logic [7:0]                         appear_type;
        logic [7:0]                         manu_type;
        logic [15:0]                        phone_code;
        logic [3:0]                         id_count;
        logic [TABLE_ENTRIES-1:0][15:0]     id_table;
    } t_cfg;

    // one verdict
    typedef struct packed {
        logic        is_phone;
        t_kind       match_kind;
        logic [15:0] appearance_value;
        logic [15:0] company_value;
    } t_result;

endpackage

### hw/rtl/adp_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adp_walker
// Walks the AD structures of a report one byte per step, keeps the first
// appearance and manufacturer structures and forms the verdict on the last
// byte from the updated state.
// ----------------------------------------------------------------------------
module adp_walker #(
    parameter int MAX_REPORT_BYTES = 255,
    parameter int ID_SLOTS         = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  adp_pkg::t_cfg    i_cfg,
    output adp_pkg::t_result o_result
);
    import adp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_byte_pos, n_byte_pos;
    logic [8:0]  r_next_hdr, n_next_hdr;
    logic [7:0]  r_cur_len, n_cur_len;
    logic        r_halted, n_halted;
    logic        r_app_seen, n_app_seen;
    logic [8:0]  r_app_end, n_app_end;
    logic [7:0]  r_app_len, n_app_len;
    logic [15:0] r_app_word, n_app_word;
    logic        r_manu_seen, n_manu_seen;
    logic [8:0]  r_manu_end, n_manu_end;
    logic [7:0]  r_manu_len, n_manu_len;
    logic [15:0] r_manu_word, n_manu_word;

    logic        active;
    logic        walk;
    logic [8:0]  pos9;
    logic [8:0]  type_end;
    logic [8:0]  pay_start;
    logic [8:0]  pay_offset;
    logic [3:0]  id_limit;

    assign active     = r_byte_pos < 8'(MAX_REPORT_BYTES);
    assign walk       = active && !r_halted;
    assign pos9       = {1'b0, r_byte_pos};
    assign type_end   = r_next_hdr - 9'd1;
    assign pay_start  = r_next_hdr - {1'b0, r_cur_len} + 9'd1;
    assign pay_offset = pos9 - pay_start;
    assign id_limit   = (i_cfg.id_count > 4'(ID_SLOTS)) ? 4'(ID_SLOTS) : i_cfg.id_count;

    // place a payload byte into the first two bytes of a word
    function automatic logic [15:0] put_byte(logic [15:0] word, logic [8:0] offset,
                                             logic [7:0] b);
        logic [15:0] res;
        res = word;
        if (offset == 9'd0) begin
            res[7:0] = b;
        end else if (offset == 9'd1) begin
            res[15:8] = b;
        end
        return res;
    endfunction

    // company id lookup over the first limit entries
    function automatic logic id_match(logic [TABLE_ENTRIES-1:0][15:0] tab,
                                      logic [3:0] limit, logic [15:0] id);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if ((4'(i) < limit) && (tab[i] == id)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // next walk phase
    always_comb begin
        n_phase = r_phase;
        if (walk) begin
            case (r_phase)
                PH_LENGTH: begin
                    if (i_byte != 8'd0) begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_phase = (r_cur_len == 8'd1) ? PH_LENGTH : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (pos9 + 9'd1 == r_next_hdr) begin
                        n_phase = PH_LENGTH;
                    end
                end
                default: n_phase = PH_LENGTH;
            endcase
        end
    end

    // structure bookkeeping per byte
    always_comb begin
        n_byte_pos  = r_byte_pos;
        n_next_hdr  = r_next_hdr;
        n_cur_len   = r_cur_len;
        n_halted    = r_halted;
        n_app_seen  = r_app_seen;
        n_app_end   = r_app_end;
        n_app_len   = r_app_len;
        n_app_word  = r_app_word;
        n_manu_seen = r_manu_seen;
        n_manu_end  = r_manu_end;
        n_manu_len  = r_manu_len;
        n_manu_word = r_manu_word;
        if (walk) begin
            case (r_phase)
                PH_LENGTH: begin
                    if (i_byte == 8'd0) begin
                        n_halted = 1'b1;
                    end else begin
                        n_cur_len  = i_byte;
                        n_next_hdr = pos9 + {1'b0, i_byte} + 9'd1;
                    end
                end
                PH_TYPE: begin
                    if (i_byte == i_cfg.appear_type && !r_app_seen) begin
                        n_app_seen = 1'b1;
                        n_app_end  = type_end;
                        n_app_len  = r_cur_len - 8'd1;
                        n_app_word = 16'd0;
                    end
                    if (i_byte == i_cfg.manu_type && !r_manu_seen) begin
                        n_manu_seen = 1'b1;
                        n_manu_end  = type_end;
                        n_manu_len  = r_cur_len - 8'd1;
                        n_manu_word = 16'd0;
                    end
                end
                PH_PAYLOAD: begin
                    if (r_app_seen && (r_app_end + 9'd1 == r_next_hdr)) begin
                        n_app_word = put_byte(r_app_word, pay_offset, i_byte);
                    end
                    if (r_manu_seen && (r_manu_end + 9'd1 == r_next_hdr)) begin
                        n_manu_word = put_byte(r_manu_word, pay_offset, i_byte);
                    end
                end
                default: n_halted = r_halted;
            endcase
        end
        if (active) begin
            n_byte_pos = r_byte_pos + 8'd1;
        end
    end

    // verdict from the state after this byte
    always_comb begin
        logic app_valid;
        logic manu_valid;
        logic app_long;
        logic manu_long;
        app_valid  = n_app_seen && (n_app_end < {1'b0, n_byte_pos});
        manu_valid = n_manu_seen && (n_manu_end < {1'b0, n_byte_pos});
        app_long   = n_app_len >= 8'd2;
        manu_long  = n_manu_len >= 8'd2;
        o_result.appearance_value = (app_valid && app_long) ? n_app_word : 16'd0;
        o_result.company_value    = (manu_valid && manu_long) ? n_manu_word : 16'd0;
        o_result.match_kind       = KIND_NONE;
        if (app_valid) begin
            if (app_long && (n_app_word == i_cfg.phone_code)) begin
                o_result.match_kind = KIND_APPEAR;
            end
        end else if (manu_valid && manu_long
                     && id_match(i_cfg.id_table, id_limit, n_manu_word)) begin
            o_result.match_kind = KIND_COMPANY;
        end
        o_result.is_phone = (o_result.match_kind != KIND_NONE);
    end

    // walk state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase     <= PH_LENGTH;
            r_byte_pos  <= '0;
            r_next_hdr  <= '0;
            r_cur_len   <= '0;
            r_halted    <= 1'b0;
            r_app_seen  <= 1'b0;
            r_app_end   <= '0;
            r_app_len   <= '0;
            r_app_word  <= '0;
            r_manu_seen <= 1'b0;
            r_manu_end  <= '0;
            r_manu_len  <= '0;
            r_manu_word <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_next_hdr  <= n_next_hdr;
            r_cur_len   <= n_cur_len;
            r_halted    <= n_halted;
            r_app_seen  <= n_app_seen;
            r_app_end   <= n_app_end;
            r_app_len   <= n_app_len;
            r_app_word  <= n_app_word;
            r_manu_seen <= n_manu_seen;
            r_manu_end  <= n_manu_end;
            r_manu_len  <= n_manu_len;
            r_manu_word <= n_manu_word;
        end
    end

endmodule

### hw/rtl/adv_data_phone_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adv_data_phone_classifier
// Classifies an advertising report as phone or not from its AD structures.
// ----------------------------------------------------------------------------
// Usage:
//   Report bytes enter on the s_axis channel, one item per byte, tlast on
//   the final byte. One verdict item leaves on m_axis per report, carrying
//   the appearance and company values in tdata and the verdict in tuser.
//   The configuration port writes a register at any edge with i_cfg_we
//   high; write only while no report is in flight.
//   Throughput is one byte per cycle while no last byte waits on a stalled
//   receiver: each byte goes from the input register through the walker
//   logic in a single pass. A last byte moves from the input register
//   through the walker into the result register, which drives m_axis.
//   When the receiver stalls with a verdict pending, bytes of the next
//   report keep flowing; only a further last byte waits in the input
//   register, and s_axis tready drops until the verdict is taken.
//   Reset loads the register defaults and clears the walk and both
//   channel stages.
// ----------------------------------------------------------------------------
module adv_data_phone_classifier #(
    parameter int MAX_REPORT_BYTES = 255,
    parameter int ID_SLOTS         = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    // report bytes
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] report_byte
    input  logic        i_s_axis_tlast,   // report_last
    // verdicts
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] appearance_value, [31:16] company_value
    output logic [2:0]  o_m_axis_tuser    // [0] is_phone, [2:1] match_kind
);
    import adp_pkg::*;

    logic [7:0]  r_appear_type;
    logic [7:0]  r_manu_type;
    logic [15:0] r_phone_code;
    logic [3:0]  r_id_count;
    logic [63:0] r_id_word_a;
    logic [63:0] r_id_word_b;
    logic [63:0] r_id_word_c;
    t_cfg        cfg;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     walk_result;
    logic        advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_appear_type <= RST_APPEAR_TYPE;
            r_manu_type   <= RST_MANU_TYPE;
            r_phone_code  <= RST_PHONE_CODE;
            r_id_count    <= '0;
            r_id_word_a   <= '0;
            r_id_word_b   <= '0;
            r_id_word_c   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_APPEAR_TYPE: r_appear_type <= i_cfg_wdata[7:0];
                REG_MANU_TYPE:   r_manu_type   <= i_cfg_wdata[7:0];
                REG_PHONE_CODE:  r_phone_code  <= i_cfg_wdata[15:0];
                REG_ID_COUNT:    r_id_count    <= i_cfg_wdata[3:0];
                REG_ID_WORD_A:   r_id_word_a   <= i_cfg_wdata;
                REG_ID_WORD_B:   r_id_word_b   <= i_cfg_wdata;
                REG_ID_WORD_C:   r_id_word_c   <= i_cfg_wdata;
                default:         r_id_count    <= r_id_count;
            endcase
        end
    end

    // configuration bundle, fields in struct order, table entry 0 lowest
    assign cfg = {r_appear_type, r_manu_type, r_phone_code, r_id_count,
                  r_id_word_c, r_id_word_b, r_id_word_a};

    // input stage moves on unless a last byte meets a blocked result register
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // structure walk and verdict
    adp_walker #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES),
        .ID_SLOTS         (ID_SLOTS)
    ) u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_cfg    (cfg),
        .o_result (walk_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= walk_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.company_value, r_out.appearance_value};
    assign o_m_axis_tuser  = {r_out.match_kind, r_out.is_phone};

    // checks
    a_phone_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_phone == (r_out.match_kind != KIND_NONE)))
        else $error("is_phone disagrees with match_kind");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.match_kind != 2'd3))
        else $error("undefined match_kind");

    a_last_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while a last byte is blocked");

    a_verdict_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_last) |=> o_m_axis_tvalid)
        else $error("last byte processed without a verdict");

endmodule
